[src/i2ctfr_pkg.sv]
package i2ctfr_pkg;

  localparam int RX_FRAME_LEN = 9;
  localparam int TX_FRAME_LEN = 15;
  localparam int STORE_DEPTH  = 16;
  localparam int IDX_W        = $clog2(STORE_DEPTH);
  localparam int PTR_W        = 5;
  localparam int PAYLOAD_LEN  = 12;

  // reply layout
  localparam logic [IDX_W-1:0] POS_MODE_ID = IDX_W'(12);
  localparam logic [IDX_W-1:0] POS_FRAME   = IDX_W'(13);
  localparam logic [IDX_W-1:0] POS_SUM     = IDX_W'(14);

  typedef enum logic [1:0] {
    ACT_BUS   = 2'd0,
    ACT_RX    = 2'd1,
    ACT_READ  = 2'd2,
    ACT_BUILD = 2'd3
  } action_t;

  typedef logic [7:0] byte_t;

  localparam byte_t PAYLOAD_TABLE [4][PAYLOAD_LEN] = '{
    '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h48, 8'h61, 8'h6E, 8'h64, 8'h72, 8'h61, 8'h64, 8'h20, 8'h30, 8'h30, 8'h30, 8'h31},
    '{8'h3B, 8'h59, 8'hE8, 8'h2A, 8'hE9, 8'hB1, 8'hBE, 8'hD8, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h41, 8'h42, 8'h43, 8'h44, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38}
  };

  localparam byte_t MODE_IDS [4] = '{8'd1, 8'd3, 8'd4, 8'd5};

  // byte of the reply header area (positions 0..12) for a given mode
  function automatic byte_t header_byte(input logic [1:0] mode, input logic [IDX_W-1:0] pos);
    byte_t b;
    b = 8'h00;
    if (pos < IDX_W'(PAYLOAD_LEN)) begin
      b = PAYLOAD_TABLE[mode][pos];
    end else if (pos == POS_MODE_ID) begin
      b = MODE_IDS[mode];
    end
    return b;
  endfunction

  // controller -> datapath
  typedef struct packed {
    logic event_go;     // accept of a bus/rx/read request
    logic build_start;  // accept of a build request
    logic build_step;   // write one reply byte
    logic build_finish; // write checksum, load result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fill_last;    // step writing the frame number
  } stat_t;

endpackage

[src/i2ctfr_ctrl.sv]
module i2ctfr_ctrl
  import i2ctfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] action,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  stat_t      stat,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_BUILD  = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   accept;
  logic   load_out;
  logic   out_valid_next;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next       = state;
    cmd              = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action_t'(action) == ACT_BUILD) begin
            cmd.build_start = 1'b1;
            state_next      = ST_BUILD;
          end else begin
            cmd.event_go = 1'b1;
          end
        end
      end
      ST_BUILD: begin
        cmd.build_step = 1'b1;
        if (stat.fill_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.build_finish = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign load_out       = cmd.event_go || cmd.build_finish;
  assign out_valid_next = load_out || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[src/i2ctfr_dp.sv]
module i2ctfr_dp
  import i2ctfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] action,
  input  logic [7:0] rx_byte,
  input  logic       first_byte,
  input  logic [1:0] reply_mode,
  input  cmd_t       cmd,
  output stat_t      stat,
  output logic [7:0] read_data,
  output logic       rx_frame_done,
  output logic       rx_overrun,
  output logic       tx_overrun
);

  byte_t            tx_store [STORE_DEPTH];
  logic [PTR_W-1:0] rx_index, rx_index_next;
  logic [PTR_W-1:0] tx_index, tx_index_next;
  logic [7:0]       frame_counter;
  logic [1:0]       mode;
  logic [IDX_W-1:0] step;
  byte_t            sum;

  logic [PTR_W-1:0] rx_base, rx_inc, tx_inc;
  logic             done_c, rx_ovr_c, tx_ovr_c;
  byte_t            data_c, step_byte;

  // Incoming bytes are only counted: rx_byte is never stored,
  // so its value never reaches a result.
  always_comb begin
    rx_index_next = rx_index;
    tx_index_next = tx_index;
    done_c        = 1'b0;
    rx_ovr_c      = 1'b0;
    tx_ovr_c      = 1'b0;
    data_c        = 8'h00;
    rx_base       = first_byte ? '0 : rx_index;
    rx_inc        = rx_base + PTR_W'(1);
    tx_inc        = tx_index + PTR_W'(1);
    unique case (action_t'(action))
      ACT_BUS: begin
        rx_index_next = '0;
        tx_index_next = '0;
      end
      ACT_RX: begin
        rx_index_next = rx_inc;
        done_c        = (rx_inc == PTR_W'(RX_FRAME_LEN));
        if (rx_inc > PTR_W'(RX_FRAME_LEN)) begin
          rx_index_next = '0;
          rx_ovr_c      = 1'b1;
        end
      end
      ACT_READ: begin
        data_c        = tx_store[tx_index[IDX_W-1:0]];
        tx_index_next = tx_inc;
        if (tx_inc > PTR_W'(TX_FRAME_LEN)) begin
          tx_index_next = '0;
          tx_ovr_c      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign step_byte      = (step == POS_FRAME) ? frame_counter : header_byte(mode, step);
  assign stat.fill_last = (step == POS_FRAME);

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_index      <= '0;
      tx_index      <= '0;
      frame_counter <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        tx_store[i] <= 8'(i);
      end
    end else begin
      if (cmd.event_go) begin
        rx_index <= rx_index_next;
        tx_index <= tx_index_next;
      end
      if (cmd.build_step) begin
        tx_store[step] <= step_byte;
        if (step == POS_FRAME) begin
          frame_counter <= frame_counter + 8'd1;
        end
      end
      if (cmd.build_finish) begin
        tx_store[POS_SUM] <= sum;
      end
    end
  end

  // build sequencer and result register
  always_ff @(posedge clk) begin
    if (cmd.build_start) begin
      mode <= reply_mode;
      step <= '0;
      sum  <= 8'h00;
    end else if (cmd.build_step) begin
      step <= step + IDX_W'(1);
      if (step <= POS_MODE_ID) begin
        sum <= (sum ^ step_byte) + 8'd1;
      end
    end
    if (cmd.event_go) begin
      read_data     <= data_c;
      rx_frame_done <= done_c;
      rx_overrun    <= rx_ovr_c;
      tx_overrun    <= tx_ovr_c;
    end else if (cmd.build_finish) begin
      read_data     <= sum;
      rx_frame_done <= 1'b0;
      rx_overrun    <= 1'b0;
      tx_overrun    <= 1'b0;
    end
  end

endmodule

[src/i2c_target_frame_responder.sv]
// Channel | Handshake            | Payload
// --------+----------------------+---------------------------------------------
// in      | in_valid / in_stall  | action, rx_byte, first_byte, reply_mode
// out     | out_valid / out_stall| read_data, rx_frame_done, rx_overrun,
//         |                      | tx_overrun
//
// Bus start/stop, received byte and read requests finish in the accept cycle;
// the result lands in the output register on the next edge.
// A build request: accept, 14 byte writes into the transmit buffer (the first
// 13 folded into the checksum one byte per cycle), then the checksum write.
// rst is synchronous: indices and frame counter clear, transmit buffer
// entry i reloads with i.
// in_stall stays high during a build and while an unread result is stalled.
module i2c_target_frame_responder
  import i2ctfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] rx_byte,
  input  logic       first_byte,
  input  logic [1:0] reply_mode,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       rx_frame_done,
  output logic       rx_overrun,
  output logic       tx_overrun
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: decides when a request is taken, steps the reply build and
  // owns the result valid flag.
  i2ctfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Transmit buffer, indices, frame counter, checksum and the result register.
  i2ctfr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .action        (action),
    .rx_byte       (rx_byte),
    .first_byte    (first_byte),
    .reply_mode    (reply_mode),
    .cmd           (cmd),
    .stat          (stat),
    .read_data     (read_data),
    .rx_frame_done (rx_frame_done),
    .rx_overrun    (rx_overrun),
    .tx_overrun    (tx_overrun)
  );

endmodule
